### hdl/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg: sector cache shared definitions
// access kinds and the packing of the result stream word
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int KIND_W     = 2;
  localparam int SECTOR_W   = 32;
  localparam int SLOT_OUT_W = 6;
  localparam int OUT_DATA_W = 48;

  localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd2;

  // result word bit positions
  localparam int OUT_HIT_BIT   = 6;
  localparam int OUT_FILL_BIT  = 7;
  localparam int OUT_WB_BIT    = 8;
  localparam int OUT_WBSEC_LSB = 9;
  localparam int OUT_WBSEC_MSB = OUT_WBSEC_LSB + SECTOR_W - 1;

endpackage

### hdl/sector_cache_clock_replacement.sv
// ----------------------------------------------------------------------------
// sector_cache_clock_replacement: sector cache metadata with clock replacement
// fully associative tag lookup, clock victim choice, write-back and flush
// ----------------------------------------------------------------------------
//  channel | direction | tdata                    | tuser | tlast
//  in_     | slave     | sector                   | kind  | -
//  out_    | master    | slot, hit, fill, wb, sec | -     | last
//
//  an access scans the tags through the metadata memories and, on a miss,
//  then runs the clock sweep to choose a victim
//  a flush scans one entry per cycle up to the last dirty entry unless the output stalls
//  after reset a clearing pass over all entries keeps in_tready low
//  a stalled result holds in the output register; the next transaction is
//  still taken, and a flush waits on the entry whose result cannot be loaded
// ----------------------------------------------------------------------------
module sector_cache_clock_replacement
  import scc_pkg::*;
#(
  parameter int ENTRIES     = 64,
  parameter int SECTOR_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [SECTOR_W-1:0]   in_tdata,   // sector
  input  logic [KIND_W-1:0]     in_tuser,   // kind
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // slot, hit, fill_needed,
                                            // writeback_needed, writeback_sector
  output logic                  out_tlast   // last
);

  localparam int SLOT_W = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES - 1);

  typedef struct packed {
    logic valid;
    logic dirty;
    logic accessed;
  } flags_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_SWEEP,
    ST_FINISH,
    ST_FLUSH
  } state_t;

  flags_t                 flag_mem [ENTRIES];
  logic [SECTOR_BITS-1:0] tag_mem  [ENTRIES];

  state_t                 state_r, state_nxt;
  logic [SLOT_W-1:0]      clr_addr_r, clr_addr_nxt;
  logic [SLOT_W-1:0]      hand_r, hand_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0]  out_tdata_r, out_tdata_nxt;
  logic                   out_tlast_r, out_tlast_nxt;

  logic [KIND_W-1:0]      kind_r, kind_nxt;
  logic [SECTOR_BITS-1:0] tag_r, tag_nxt;
  logic [SLOT_W-1:0]      chk_addr_r;
  logic [SLOT_W-1:0]      res_slot_r, res_slot_nxt;
  logic                   res_hit_r, res_hit_nxt;
  logic                   res_fill_r, res_fill_nxt;
  logic                   res_wb_r, res_wb_nxt;
  logic [SECTOR_W-1:0]    res_wbsec_r, res_wbsec_nxt;
  logic                   res_old_dirty_r, res_old_dirty_nxt;

  flags_t                 flag_q;
  logic [SECTOR_BITS-1:0] tag_q;
  logic [63:0]            tag_q_ext;
  logic [SECTOR_W-1:0]    tag_q_out;

  logic [SLOT_W-1:0]      rd_addr;
  logic [SLOT_W-1:0]      next_addr;
  logic                   flag_we;
  logic [SLOT_W-1:0]      flag_wa;
  flags_t                 flag_wd;
  logic                   tag_we;
  logic                   can_load;
  logic                   match;
  logic                   new_dirty;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  assign can_load  = !out_tvalid_r || out_tready;
  assign next_addr = (chk_addr_r == LAST_SLOT) ? '0 : chk_addr_r + 1'b1;
  assign match     = flag_q.valid && (tag_q == tag_r);
  assign tag_q_ext = 64'(tag_q);
  assign tag_q_out = tag_q_ext[SECTOR_W-1:0];
  assign new_dirty = (res_hit_r && res_old_dirty_r) || (kind_r == KIND_WRITE);

  always_comb begin
    state_nxt         = state_r;
    clr_addr_nxt      = clr_addr_r;
    hand_nxt          = hand_r;
    cnt_nxt           = cnt_r;
    kind_nxt          = kind_r;
    tag_nxt           = tag_r;
    res_slot_nxt      = res_slot_r;
    res_hit_nxt       = res_hit_r;
    res_fill_nxt      = res_fill_r;
    res_wb_nxt        = res_wb_r;
    res_wbsec_nxt     = res_wbsec_r;
    res_old_dirty_nxt = res_old_dirty_r;
    out_tvalid_nxt    = out_tready ? 1'b0 : out_tvalid_r;
    out_tdata_nxt     = out_tdata_r;
    out_tlast_nxt     = out_tlast_r;
    rd_addr           = chk_addr_r;
    flag_we           = 1'b0;
    flag_wa           = chk_addr_r;
    flag_wd           = flag_q;
    tag_we            = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        flag_we      = 1'b1;
        flag_wa      = clr_addr_r;
        flag_wd      = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_SLOT) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        rd_addr = '0;
        if (in_tvalid) begin
          kind_nxt = in_tuser;
          tag_nxt  = SECTOR_BITS'(in_tdata);
          case (in_tuser)
            KIND_READ, KIND_WRITE: state_nxt = ST_LOOKUP;
            KIND_FLUSH: begin
              if (cnt_r != '0) begin
                state_nxt = ST_FLUSH;
              end
            end
            default: ;
          endcase
        end
      end
      ST_LOOKUP: begin
        if (match) begin
          res_slot_nxt      = chk_addr_r;
          res_hit_nxt       = 1'b1;
          res_fill_nxt      = 1'b0;
          res_wb_nxt        = 1'b0;
          res_wbsec_nxt     = '0;
          res_old_dirty_nxt = flag_q.dirty;
          state_nxt         = ST_FINISH;
        end else if (chk_addr_r == LAST_SLOT) begin
          rd_addr   = hand_r;
          state_nxt = ST_SWEEP;
        end else begin
          rd_addr = next_addr;
        end
      end
      ST_SWEEP: begin
        if (flag_q.accessed) begin
          // second chance: clear and move on
          flag_we          = 1'b1;
          flag_wd.accessed = 1'b0;
          rd_addr          = next_addr;
        end else begin
          res_slot_nxt      = chk_addr_r;
          res_hit_nxt       = 1'b0;
          res_fill_nxt      = 1'b1;
          res_wb_nxt        = flag_q.valid && flag_q.dirty;
          res_wbsec_nxt     = (flag_q.valid && flag_q.dirty) ? tag_q_out : '0;
          res_old_dirty_nxt = flag_q.valid && flag_q.dirty;
          hand_nxt          = next_addr;
          state_nxt         = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (can_load) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = OUT_DATA_W'({res_wbsec_r, res_wb_r, res_fill_r, res_hit_r,
                                        SLOT_OUT_W'(res_slot_r)});
          out_tlast_nxt  = 1'b1;
          flag_we        = 1'b1;
          flag_wa        = res_slot_r;
          flag_wd        = '{valid: 1'b1, dirty: new_dirty, accessed: 1'b1};
          tag_we         = !res_hit_r;
          cnt_nxt        = cnt_r - CNT_W'(res_old_dirty_r) + CNT_W'(new_dirty);
          state_nxt      = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (flag_q.dirty) begin
          if (can_load) begin
            out_tvalid_nxt = 1'b1;
            out_tdata_nxt  = OUT_DATA_W'({tag_q_out, 1'b1, 1'b0, 1'b0,
                                          SLOT_OUT_W'(chk_addr_r)});
            out_tlast_nxt  = (cnt_r == CNT_W'(1));
            flag_we        = 1'b1;
            flag_wd.dirty  = 1'b0;
            cnt_nxt        = cnt_r - 1'b1;
            rd_addr        = next_addr;
            if (cnt_r == CNT_W'(1)) begin
              state_nxt = ST_IDLE;
            end
          end else begin
            // reread this entry until the output register frees up
            rd_addr = chk_addr_r;
          end
        end else begin
          rd_addr = next_addr;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      hand_r       <= '0;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      hand_r       <= hand_nxt;
      cnt_r        <= cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r     <= out_tdata_nxt;
    out_tlast_r     <= out_tlast_nxt;
    kind_r          <= kind_nxt;
    tag_r           <= tag_nxt;
    chk_addr_r      <= rd_addr;
    res_slot_r      <= res_slot_nxt;
    res_hit_r       <= res_hit_nxt;
    res_fill_r      <= res_fill_nxt;
    res_wb_r        <= res_wb_nxt;
    res_wbsec_r     <= res_wbsec_nxt;
    res_old_dirty_r <= res_old_dirty_nxt;
  end

  // metadata memories, one write and one registered read port each
  always_ff @(posedge clk) begin
    if (flag_we) begin
      flag_mem[flag_wa] <= flag_wd;
    end
    if (tag_we) begin
      tag_mem[res_slot_r] <= tag_r;
    end
    flag_q <= flag_mem[rd_addr];
    tag_q  <= tag_mem[rd_addr];
  end

endmodule

### hdl/scc_checker.sv
// ----------------------------------------------------------------------------
// scc_checker: port-level checks for the sector cache
// result field consistency, reset behavior and output stall hold
// ----------------------------------------------------------------------------
module scc_checker
  import scc_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  // clearing pass blocks input right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready right after reset");

  a_hit_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_HIT_BIT] |->
      !out_tdata[OUT_FILL_BIT] && !out_tdata[OUT_WB_BIT] && out_tlast)
    else $error("hit result with fill or write-back");

  a_flush_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[OUT_HIT_BIT] && !out_tdata[OUT_FILL_BIT] |->
      out_tdata[OUT_WB_BIT])
    else $error("flush result without write-back");

  a_wb_sector_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[OUT_WB_BIT] |->
      out_tdata[OUT_WBSEC_MSB:OUT_WBSEC_LSB] == '0)
    else $error("write-back sector set without write-back");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

endmodule

bind sector_cache_clock_replacement scc_checker u_scc_checker (.*);
